// File: sv/yuv_to_bgr_pixel_converter_macros.svh
// Assertion helpers used by the converter FIFO.
`ifndef YUV_TO_BGR_PIXEL_CONVERTER_MACROS_SVH
`define YUV_TO_BGR_PIXEL_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define YBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ybc assertion failed");
// next-cycle implication
`define YBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ybc assertion failed");
`else
`define YBC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define YBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/ybc_pkg.sv
package ybc_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = 13;
  localparam int COL_W       = 12;
  localparam int OFFSET_W    = 26;
  localparam int PROD_W      = 27;
  localparam int TERM_W      = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Q16 color coefficients
  localparam logic signed [18:0] COEF_RV = 19'sd74700;
  localparam logic signed [18:0] COEF_GU = 19'sd25864;
  localparam logic signed [18:0] COEF_GV = 19'sd38050;
  localparam logic signed [18:0] COEF_BU = 19'sd133176;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // front -> back item
  typedef struct packed {
    logic [7:0]               luma;
    logic signed [PROD_W-1:0] prod_rv;
    logic signed [PROD_W-1:0] prod_gu;
    logic signed [PROD_W-1:0] prod_gv;
    logic signed [PROD_W-1:0] prod_bu;
    logic [OFFSET_W-1:0]      pix_base;
    logic [COL_W-1:0]         column;
    logic                     misaligned;
  } prod_item_t;

  typedef struct packed {
    logic [7:0]          byte_first;
    logic [7:0]          byte_middle;
    logic [7:0]          byte_last;
    logic [OFFSET_W-1:0] byte_offset;
    logic                misaligned;
  } pix_out_t;

endpackage

// File: sv/yuv_to_bgr_pixel_converter.sv
// Converts one YUV pixel (luma plus the U/V of its 2x2 block) to 8-bit color with
// BT.601 coefficients in Q16, terms truncated toward zero and clamped to 0..255.
// When frame_width is a multiple of four the bytes come out B,G,R with the offset
// into a bottom-up frame; otherwise R,G,B at the top-down offset and tuser set.
// One pixel is accepted per clock while in_tready is high; its result passes the multiply
// stage, four-entry queue and output register before it is presented. A stalled
// output backs up into in_tready once six items are held. frame_width/frame_height
// writes above 4096 saturate to 4096 and must only be made while the converter is empty.
module yuv_to_bgr_pixel_converter import ybc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,   // luma, chroma_u, chroma_v, column, row_index
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,  // byte_first, byte_middle, byte_last, byte_offset
  output logic [0:0]       out_tuser,  // misaligned
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata
);

  logic [DIM_W-1:0] frame_width_r, frame_width_nxt;
  logic [DIM_W-1:0] frame_height_r, frame_height_nxt;
  logic [DIM_W-1:0] cfg_sat;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  prod_item_t       push_item, pop_item;
  pix_out_t         res;

  assign cfg_sat = (cfg_wdata > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_wdata;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_sat;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_W'(640);
      frame_height_r <= DIM_W'(480);
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  ybc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  ybc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ybc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {6'd0, res.byte_offset, res.byte_last, res.byte_middle, res.byte_first};
  assign out_tuser = res.misaligned;

endmodule

// File: sv/ybc_fifo.sv
`include "yuv_to_bgr_pixel_converter_macros.svh"

module ybc_fifo import ybc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  prod_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output prod_item_t pop_item
);

  prod_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `YBC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= (QPTR_W+1)'(QUEUE_DEPTH))
  `YBC_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)
  `YBC_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_r == $past(count_r) - 1'b1)
  `YBC_ASSERT_NOW(a_ptr_gap, clk, rst_n, count_r != '0 && count_r != (QPTR_W+1)'(QUEUE_DEPTH),
                  wr_ptr_r != rd_ptr_r)

endmodule

// File: sv/ybc_front.sv
module ybc_front import ybc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,
  input  logic [DIM_W-1:0] frame_width,
  input  logic [DIM_W-1:0] frame_height,
  output logic             push_valid,
  input  logic             push_ready,
  output prod_item_t       push_item
);

  logic              s1_valid_r, s1_valid_nxt;
  prod_item_t        item_r, item_nxt;
  logic              advance;
  logic              aligned;
  logic [7:0]        luma, chroma_u, chroma_v;
  logic [COL_W-1:0]  column, row_index;
  logic signed [7:0] uu, vv;
  logic [OFFSET_W-1:0] row_term;

  assign luma      = in_tdata[7:0];
  assign chroma_u  = in_tdata[15:8];
  assign chroma_v  = in_tdata[23:16];
  assign column    = in_tdata[35:24];
  assign row_index = in_tdata[47:36];

  // x - 128 is x with its top bit flipped, read as signed
  assign uu = {~chroma_u[7], chroma_u[6:0]};
  assign vv = {~chroma_v[7], chroma_v[6:0]};

  // width*3 mod 4 == 0 exactly when width mod 4 == 0
  assign aligned = (frame_width[1:0] == 2'b00);

  assign row_term = aligned ?
      (OFFSET_W'(frame_height) - OFFSET_W'(1) - OFFSET_W'(row_index)) :
      OFFSET_W'(row_index);

  assign advance   = !s1_valid_r || push_ready;
  assign in_tready = advance;

  always_comb begin
    item_nxt            = item_r;
    s1_valid_nxt        = s1_valid_r;
    if (advance) begin
      s1_valid_nxt = in_tvalid;
    end
    if (advance && in_tvalid) begin
      item_nxt.luma       = luma;
      item_nxt.prod_rv    = PROD_W'(COEF_RV) * PROD_W'(vv);
      item_nxt.prod_gu    = PROD_W'(COEF_GU) * PROD_W'(uu);
      item_nxt.prod_gv    = PROD_W'(COEF_GV) * PROD_W'(vv);
      item_nxt.prod_bu    = PROD_W'(COEF_BU) * PROD_W'(uu);
      item_nxt.pix_base   = row_term * OFFSET_W'(frame_width);
      item_nxt.column     = column;
      item_nxt.misaligned = !aligned;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign push_valid = s1_valid_r;
  assign push_item  = item_r;

endmodule

// File: sv/ybc_back.sv
module ybc_back import ybc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  prod_item_t pop_item,
  output logic       res_valid,
  input  logic       res_ready,
  output pix_out_t   res
);

  logic                     res_valid_r, res_valid_nxt;
  pix_out_t                 res_r, res_nxt;
  logic                     take;
  logic signed [PROD_W:0]   g_sum;
  logic signed [TERM_W-1:0] r_term, g_term, b_term;
  logic [7:0]               r_byte, g_byte, b_byte;
  logic [OFFSET_W-1:0]      pix, offset;

  // divide by 2^16, rounding toward zero
  function automatic logic signed [TERM_W-1:0] trunc_q16(input logic signed [PROD_W:0] x);
    logic signed [PROD_W:0] q;
    q = x >>> 16;
    if (x[PROD_W] && (x[15:0] != 16'd0)) begin
      q = q + (PROD_W+1)'(1);
    end
    return TERM_W'(q);
  endfunction

  function automatic logic [7:0] clamp_add(input logic [7:0] y,
                                           input logic signed [TERM_W-1:0] t);
    logic signed [TERM_W:0] s;
    s = (TERM_W+1)'($signed({1'b0, y})) + (TERM_W+1)'(t);
    if (s < 0) begin
      return 8'd0;
    end else if (s > (TERM_W+1)'(255)) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  assign g_sum  = -((PROD_W+1)'(pop_item.prod_gu) + (PROD_W+1)'(pop_item.prod_gv));
  assign r_term = trunc_q16((PROD_W+1)'(pop_item.prod_rv));
  assign g_term = trunc_q16(g_sum);
  assign b_term = trunc_q16((PROD_W+1)'(pop_item.prod_bu));

  assign r_byte = clamp_add(pop_item.luma, r_term);
  assign g_byte = clamp_add(pop_item.luma, g_term);
  assign b_byte = clamp_add(pop_item.luma, b_term);

  assign pix    = pop_item.pix_base + OFFSET_W'(pop_item.column);
  assign offset = pix + {pix[OFFSET_W-2:0], 1'b0};

  assign pop_ready = !res_valid_r || res_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    if (pop_ready) begin
      res_valid_nxt = pop_valid;
    end
    if (take) begin
      res_nxt.byte_first  = pop_item.misaligned ? r_byte : b_byte;
      res_nxt.byte_middle = g_byte;
      res_nxt.byte_last   = pop_item.misaligned ? b_byte : r_byte;
      res_nxt.byte_offset = offset;
      res_nxt.misaligned  = pop_item.misaligned;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ybc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_SHOWN   = 60;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [47:0]      in_tdata;   // luma, chroma_u, chroma_v, column, row_index
  logic             out_tvalid;
  logic             out_tready;
  logic [55:0]      out_tdata;  // byte_first, byte_middle, byte_last, byte_offset, zero fill
  logic [0:0]       out_tuser;  // misaligned
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  yuv_to_bgr_pixel_converter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  typedef struct {
    logic [7:0]  luma;
    logic [7:0]  chroma_u;
    logic [7:0]  chroma_v;
    logic [11:0] column;
    logic [11:0] row_index;
    bit          typed;
    pix_out_t    want;
  } pixel_row_t;

  // runs under the reset frame size 640x480, which is aligned
  pixel_row_t pixel_table [18] = '{
    '{8'd0,   8'd128, 8'd128, 12'd0,    12'd479,  1'b1, '{8'd0,   8'd0,   8'd0,   26'd0,      1'b0}},
    '{8'd255, 8'd128, 8'd128, 12'd639,  12'd0,    1'b1, '{8'd255, 8'd255, 8'd255, 26'd921597, 1'b0}},
    '{8'd0,   8'd0,   8'd0,   12'd0,    12'd479,  1'b1, '{8'd0,   8'd124, 8'd0,   26'd0,      1'b0}},
    '{8'd255, 8'd255, 8'd255, 12'd639,  12'd479,  1'b1, '{8'd255, 8'd132, 8'd255, 26'd1917,   1'b0}},
    '{8'd128, 8'd128, 8'd128, 12'd1,    12'd478,  1'b1, '{8'd128, 8'd128, 8'd128, 26'd1923,   1'b0}},
    '{8'd0,   8'd255, 8'd0,   12'd5,    12'd100,  1'b0, '{default: '0}},
    '{8'd255, 8'd0,   8'd255, 12'd6,    12'd101,  1'b0, '{default: '0}},
    '{8'd0,   8'd0,   8'd255, 12'd7,    12'd102,  1'b0, '{default: '0}},
    '{8'd0,   8'd255, 8'd255, 12'd8,    12'd103,  1'b0, '{default: '0}},
    '{8'd255, 8'd0,   8'd0,   12'd9,    12'd104,  1'b0, '{default: '0}},
    '{8'd255, 8'd255, 8'd0,   12'd10,   12'd105,  1'b0, '{default: '0}},
    // small chroma offsets: negative terms truncate toward zero
    '{8'd16,  8'd127, 8'd129, 12'd11,   12'd200,  1'b0, '{default: '0}},
    '{8'd100, 8'd129, 8'd127, 12'd12,   12'd201,  1'b0, '{default: '0}},
    // positions outside the frame, where the offset can wrap
    '{8'd60,  8'd70,  8'd80,  12'd4095, 12'd4095, 1'b0, '{default: '0}},
    '{8'd61,  8'd71,  8'd81,  12'd0,    12'd480,  1'b0, '{default: '0}},
    '{8'd62,  8'd72,  8'd82,  12'd640,  12'd0,    1'b0, '{default: '0}},
    '{8'hAA,  8'h55,  8'hAA,  12'hAAA,  12'h555,  1'b0, '{default: '0}},
    '{8'h55,  8'hAA,  8'h55,  12'h555,  12'hAAA,  1'b0, '{default: '0}}
  };

  logic [DIM_W-1:0] frame_w;
  logic [DIM_W-1:0] frame_h;
  pix_out_t         pending_pixels [$];
  bit               cur_typed;
  pix_out_t         cur_want;
  bit               in_idle_on;
  bit               out_stall_on;
  int               mismatches;
  int               cycles;
  pix_out_t         got_pixel;
  pix_out_t         want_pixel;

  function automatic logic [7:0] clamp_to_byte(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  function automatic pix_out_t convert_pixel(input logic [47:0] word);
    int          y, du, dv, r_term, g_term, b_term;
    logic [7:0]  red, green, blue;
    logic [63:0] pix_index;
    bit          aligned;
    pix_out_t    px;
    y      = int'(word[7:0]);
    du     = int'(word[15:8]) - 128;
    dv     = int'(word[23:16]) - 128;
    r_term = (74700 * dv) / 65536;
    g_term = (-(25864 * du + 38050 * dv)) / 65536;
    b_term = (133176 * du) / 65536;
    red    = clamp_to_byte(y + r_term);
    green  = clamp_to_byte(y + g_term);
    blue   = clamp_to_byte(y + b_term);
    aligned = ((64'(frame_w) * 3) % 4) == 0;
    if (aligned) begin
      pix_index = (64'(frame_h) - 64'd1 - 64'(word[47:36])) * 64'(frame_w) + 64'(word[35:24]);
      px.byte_first = blue;
      px.byte_last  = red;
    end else begin
      pix_index = 64'(word[47:36]) * 64'(frame_w) + 64'(word[35:24]);
      px.byte_first = red;
      px.byte_last  = blue;
    end
    px.byte_middle = green;
    px.byte_offset = OFFSET_W'(pix_index * 64'd3);
    px.misaligned  = !aligned;
    return px;
  endfunction

  function automatic logic [47:0] pack_pixel(input logic [7:0] y, input logic [7:0] u,
                                             input logic [7:0] v, input logic [11:0] col,
                                             input logic [11:0] row);
    return {row, col, v, u, y};
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic send_pixel(input logic [47:0] word, input bit typed, input pix_out_t want);
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_dim(input cfg_reg_t idx, input logic [DIM_W-1:0] value);
    logic [DIM_W-1:0] sat;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sat = (value > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : value;
    if (idx == REG_FRAME_WIDTH) frame_w = sat;
    else frame_h = sat;
  endtask

  task automatic random_pixels(input int count);
    logic [11:0] col, row;
    for (int i = 0; i < count; i++) begin
      // mostly in-frame positions, some anywhere in the 12-bit range
      if (frame_w != 0 && $urandom_range(0, 7) != 0)
        col = 12'($urandom_range(0, int'(frame_w) - 1));
      else
        col = 12'($urandom_range(0, 4095));
      if (frame_h != 0 && $urandom_range(0, 7) != 0)
        row = 12'($urandom_range(0, int'(frame_h) - 1));
      else
        row = 12'($urandom_range(0, 4095));
      send_pixel(pack_pixel(8'($urandom), 8'($urandom), 8'($urandom), col, row),
                 1'b0, '{default: '0});
    end
  endtask

  task automatic run_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input int count);
    wait_drained();
    if ($urandom_range(0, 1)) begin
      set_dim(REG_FRAME_WIDTH, w);
      set_dim(REG_FRAME_HEIGHT, h);
    end else begin
      set_dim(REG_FRAME_HEIGHT, h);
      set_dim(REG_FRAME_WIDTH, w);
    end
    random_pixels(count);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return DIM_W'($urandom_range(0, 8191));
      1, 2: return DIM_W'($urandom_range(2, 16));
      default: return DIM_W'($urandom_range(2, 4096));
    endcase
  endfunction

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_stall_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pending_pixels.push_back(cur_typed ? cur_want : convert_pixel(in_tdata));
      if (out_tvalid && out_tready) begin
        got_pixel.byte_first  = out_tdata[7:0];
        got_pixel.byte_middle = out_tdata[15:8];
        got_pixel.byte_last   = out_tdata[23:16];
        got_pixel.byte_offset = out_tdata[49:24];
        got_pixel.misaligned  = out_tuser[0];
        if (pending_pixels.size() == 0) begin
          report_mismatch("pixel out with none pending");
        end else begin
          want_pixel = pending_pixels.pop_front();
          if (got_pixel.byte_first != want_pixel.byte_first)
            report_mismatch($sformatf("byte_first %0d, want %0d",
                                      got_pixel.byte_first, want_pixel.byte_first));
          if (got_pixel.byte_middle != want_pixel.byte_middle)
            report_mismatch($sformatf("byte_middle %0d, want %0d",
                                      got_pixel.byte_middle, want_pixel.byte_middle));
          if (got_pixel.byte_last != want_pixel.byte_last)
            report_mismatch($sformatf("byte_last %0d, want %0d",
                                      got_pixel.byte_last, want_pixel.byte_last));
          if (got_pixel.byte_offset != want_pixel.byte_offset)
            report_mismatch($sformatf("byte_offset %0d, want %0d",
                                      got_pixel.byte_offset, want_pixel.byte_offset));
          if (got_pixel.misaligned != want_pixel.misaligned)
            report_mismatch($sformatf("misaligned %0b, want %0b",
                                      got_pixel.misaligned, want_pixel.misaligned));
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cur_typed = 1'b0;
    cur_want  = '0;
    frame_w   = DIM_W'(640);
    frame_h   = DIM_W'(480);
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    mismatches   = 0;
    cycles       = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (pixel_table[i])
      send_pixel(pack_pixel(pixel_table[i].luma, pixel_table[i].chroma_u,
                            pixel_table[i].chroma_v, pixel_table[i].column,
                            pixel_table[i].row_index),
                 pixel_table[i].typed, pixel_table[i].want);

    // zero, saturated and tiny frames and the largest one, then random sizes
    run_frame(DIM_W'(0),    DIM_W'(0),    20);
    run_frame(DIM_W'(8191), DIM_W'(5000), 40);
    run_frame(DIM_W'(1),    DIM_W'(1),    20);
    run_frame(DIM_W'(2),    DIM_W'(1),    30);
    run_frame(DIM_W'(3),    DIM_W'(2),    40);
    run_frame(DIM_W'(4097), DIM_W'(4096), 40);
    run_frame(DIM_W'(4096), DIM_W'(4096), 60);
    for (int k = 0; k < 8; k++) run_frame(pick_dim(), pick_dim(), 135);

    // tail runs at full rate on both sides
    wait_drained();
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    run_frame(pick_dim(), pick_dim(), 150);
    run_frame(DIM_W'(6), DIM_W'(7), 150);

    wait_drained();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
